### rtl/core/hpq_pkg.sv
// hpq_pkg: shared constants, types and elaboration helpers for the 4-ary heap queue
// level geometry functions, status codes and the level memory command struct
// no dependencies
package hpq_pkg;

    localparam int DATA_W       = 32;
    localparam int DEF_CAPACITY = 64;
    localparam int DEF_ARITY    = 4;

    // widest index and level number over the supported parameter range
    localparam int IDX_MAX_W = 12;
    localparam int LVL_MAX_W = 4;

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] REG_HEAP_ORDER = 2'd0;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic                 rd_en;
        logic [LVL_MAX_W-1:0] rd_lvl;
        logic [IDX_MAX_W-1:0] rd_idx;
        logic                 wr_en;
        logic [LVL_MAX_W-1:0] wr_lvl;
        logic [IDX_MAX_W-1:0] wr_idx;
        logic [DATA_W-1:0]    wr_data;
    } t_mem_cmd;

    // global index of the first entry of a tree level
    function automatic int level_first(input int arity, input int lvl);
        int total;
        int pw;
        total = 0;
        pw    = 1;
        for (int k = 0; k < 32; k++) begin
            if (k < lvl) begin
                total = total + pw;
                pw    = pw * arity;
            end
        end
        return total;
    endfunction

    function automatic int num_levels(input int arity, input int capacity);
        int total;
        int pw;
        int n;
        total = 0;
        pw    = 1;
        n     = 0;
        for (int k = 0; k < 32; k++) begin
            if (total < capacity) begin
                total = total + pw;
                pw    = pw * arity;
                n     = n + 1;
            end
        end
        return n;
    endfunction

    // entries held by one level, the last level may be partial
    function automatic int level_size(input int arity, input int capacity, input int lvl);
        int pw;
        int rest;
        pw = 1;
        for (int k = 0; k < 32; k++) begin
            if (k < lvl) begin
                pw = pw * arity;
            end
        end
        rest = capacity - level_first(arity, lvl);
        return (pw < rest) ? pw : rest;
    endfunction

    // a sits strictly above b in the current order
    function automatic logic comes_before(input logic signed [DATA_W-1:0] a,
                                          input logic signed [DATA_W-1:0] b,
                                          input logic                     order);
        return order ? (a > b) : (a < b);
    endfunction

endpackage

### rtl/core/hpq_ram.sv
// hpq_ram: generic simple dual port ram, one write and one registered read port
// parameter defaults come from hpq_pkg
module hpq_ram #(
    parameter int WIDTH = hpq_pkg::DATA_W,
    parameter int DEPTH = hpq_pkg::DEF_CAPACITY
) (
    input  logic                                           i_clk,
    input  logic                                           i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]                               i_wdata,
    input  logic                                           i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

### rtl/core/hpq_cell.sv
// hpq_cell: one tree level of the heap, owns that level's entries in a ram
// passes read data from deeper levels up the chain; uses hpq_pkg and hpq_ram
module hpq_cell #(
    parameter int ARITY    = hpq_pkg::DEF_ARITY,
    parameter int CAPACITY = hpq_pkg::DEF_CAPACITY,
    parameter int LEVEL    = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hpq_pkg::t_mem_cmd           i_cmd,
    input  logic [hpq_pkg::DATA_W-1:0]  i_rdata,
    output logic [hpq_pkg::DATA_W-1:0]  o_rdata
);
    import hpq_pkg::*;

    localparam int FIRST = level_first(ARITY, LEVEL);
    localparam int DEPTH = level_size(ARITY, CAPACITY, LEVEL);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                 w_rd_hit;
    logic                 w_wr_hit;
    logic [IDX_MAX_W-1:0] w_rd_off;
    logic [IDX_MAX_W-1:0] w_wr_off;
    logic [DATA_W-1:0]    w_q;
    logic                 r_hit;

    assign w_rd_hit = i_cmd.rd_en && (i_cmd.rd_lvl == LVL_MAX_W'(LEVEL));
    assign w_wr_hit = i_cmd.wr_en && (i_cmd.wr_lvl == LVL_MAX_W'(LEVEL));

    // global heap index to position inside this level
    assign w_rd_off = i_cmd.rd_idx - IDX_MAX_W'(FIRST);
    assign w_wr_off = i_cmd.wr_idx - IDX_MAX_W'(FIRST);

    hpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_hit),
        .i_waddr (w_wr_off[AW-1:0]),
        .i_wdata (i_cmd.wr_data),
        .i_re    (w_rd_hit),
        .i_raddr (w_rd_off[AW-1:0]),
        .o_rdata (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= w_rd_hit;
        end
    end

    // this level answers the read it took last cycle, else the deeper one does
    assign o_rdata = r_hit ? w_q : i_rdata;

endmodule

### rtl/core/four_ary_heap_priority_queue.sv
// four_ary_heap_priority_queue: top level, request sequencer, config register, level chain
// uses hpq_pkg and a chain of hpq_cell, one per tree level
//
// A d-ary heap priority queue of signed 32-bit words (ARITY children per node, CAPACITY
// entries). Register heap_order at byte address 0 picks min (0) or max (1) at the root.
// An item is taken when start is high and busy is low; its single result appears on the
// o_ ports for exactly one cycle with o_done high, and the receiver cannot stall it.
// Refused items (insert when full, extract when empty) and an extract that leaves the
// heap empty answer in the cycle after being taken. An insert climbs level by level: it
// reads the parent, writes the current slot with the parent entry or the new value, and
// writes the root directly when it gets there. An extract reads the last entry, which then
// sinks from the root; the children of a node are read one per cycle from the level ram
// and compared with the moved entry before that node is settled.
// Write heap_order only while busy is low and no result is pending.
module four_ary_heap_priority_queue #(
    parameter int CAPACITY = hpq_pkg::DEF_CAPACITY,
    parameter int ARITY    = hpq_pkg::DEF_ARITY
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_req_type,
    input  logic signed [hpq_pkg::DATA_W-1:0]    i_value,
    // result channel
    output logic                                 o_done,
    output logic [1:0]                           o_status,
    output logic signed [hpq_pkg::DATA_W-1:0]    o_removed_value,
    output logic [$clog2(CAPACITY+1)-1:0]        o_entry_count,
    output logic signed [hpq_pkg::DATA_W-1:0]    o_root_value,
    output logic                                 o_root_valid,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hpq_pkg::PADDR_W-1:0]          paddr,
    input  logic [hpq_pkg::PDATA_W-1:0]          pwdata,
    output logic [hpq_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);
    import hpq_pkg::*;

    localparam int IW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int NLEV  = num_levels(ARITY, CAPACITY);
    localparam int LW    = $clog2(NLEV);
    localparam int JW    = $clog2(ARITY + 1);
    localparam int XW    = $clog2(CAPACITY * ARITY + ARITY + 1);
    // parent index by reciprocal multiply, exact for every index below 2**IW
    localparam int PS    = IW + 4;
    localparam int RECIP = (2 ** PS + ARITY - 1) / ARITY;
    localparam int PW    = IW + PS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_LAST,
        S_LAST_WAIT,
        S_DN
    } t_state;

    t_state                    r_state;
    logic [CW-1:0]             r_count;
    logic                      r_order;
    logic                      r_done;
    t_status                   r_status;
    logic signed [DATA_W-1:0]  r_removed;
    logic signed [DATA_W-1:0]  r_root;
    logic [IW-1:0]             r_g;
    logic [LW-1:0]             r_lvl;
    logic signed [DATA_W-1:0]  r_carry;
    logic signed [DATA_W-1:0]  r_best;
    logic [IW-1:0]             r_best_idx;
    logic                      r_found;
    logic [JW-1:0]             r_j;
    logic                      r_pend;
    logic [IW-1:0]             r_pend_idx;

    t_mem_cmd                  w_cmd;
    logic [DATA_W-1:0]         w_chain [NLEV+1];
    logic signed [DATA_W-1:0]  w_rd;
    logic [PW-1:0]             w_pprod;
    logic [IW-1:0]             w_parent;
    logic [XW-1:0]             w_child;
    logic                      w_issue;
    logic [CW-1:0]             w_tail;
    logic [NLEV-1:0]           w_ge;
    logic [LW-1:0]             w_tail_lvl;
    logic                      w_up_swap;
    logic                      w_dn_better;
    logic                      w_cfg_wr;

    // ---------------------------------------------------------------- level chain
    assign w_chain[NLEV] = '0;

    for (genvar k = 0; k < NLEV; k++) begin : g_lvl
        hpq_cell #(
            .ARITY    (ARITY),
            .CAPACITY (CAPACITY),
            .LEVEL    (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_rdata (w_chain[k+1]),
            .o_rdata (w_chain[k])
        );
    end

    assign w_rd = signed'(w_chain[0]);

    // ---------------------------------------------------------------- index math
    assign w_pprod  = PW'(r_g - IW'(1)) * PW'(RECIP);
    assign w_parent = w_pprod[PS +: IW];
    assign w_child  = XW'(r_g) * XW'(ARITY) + XW'(1) + XW'(r_j);

    // level of the slot an item starts from: the new tail or the last entry
    assign w_tail = (i_req_type == REQ_INSERT) ? r_count : (r_count - CW'(1));

    for (genvar k = 0; k < NLEV; k++) begin : g_ge
        localparam int FK = level_first(ARITY, k);
        if (k == 0) begin : g_root
            assign w_ge[k] = 1'b0;
        end else begin : g_deep
            assign w_ge[k] = (32'(w_tail) >= 32'(FK));
        end
    end

    assign w_tail_lvl  = LW'($countones(w_ge));

    assign w_up_swap   = comes_before(r_carry, w_rd, r_order);
    assign w_dn_better = comes_before(w_rd, r_best, r_order);
    assign w_issue     = (r_state == S_DN) && (r_j != JW'(ARITY)) &&
                         (w_child < XW'(r_count));

    // ---------------------------------------------------------------- memory command
    always_comb begin
        w_cmd = '0;
        unique case (r_state)
            S_UP: begin
                if (r_g == '0) begin
                    w_cmd.wr_en   = 1'b1;
                    w_cmd.wr_lvl  = LVL_MAX_W'(r_lvl);
                    w_cmd.wr_idx  = '0;
                    w_cmd.wr_data = r_carry;
                end else begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_lvl = LVL_MAX_W'(r_lvl) - LVL_MAX_W'(1);
                    w_cmd.rd_idx = IDX_MAX_W'(w_parent);
                end
            end
            S_UP_CMP: begin
                w_cmd.wr_en   = 1'b1;
                w_cmd.wr_lvl  = LVL_MAX_W'(r_lvl);
                w_cmd.wr_idx  = IDX_MAX_W'(r_g);
                w_cmd.wr_data = w_up_swap ? w_rd : r_carry;
            end
            S_LAST: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_lvl = LVL_MAX_W'(r_lvl);
                w_cmd.rd_idx = IDX_MAX_W'(r_g);
            end
            S_DN: begin
                if (w_issue) begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_lvl = LVL_MAX_W'(r_lvl) + LVL_MAX_W'(1);
                    w_cmd.rd_idx = IDX_MAX_W'(w_child[IW-1:0]);
                end else if (!r_pend) begin
                    // all children compared: settle this node
                    w_cmd.wr_en   = 1'b1;
                    w_cmd.wr_lvl  = LVL_MAX_W'(r_lvl);
                    w_cmd.wr_idx  = IDX_MAX_W'(r_g);
                    w_cmd.wr_data = r_found ? r_best : r_carry;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == REG_HEAP_ORDER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_order   <= 1'b0;
            r_done    <= 1'b0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_status  <= ST_OK;
            r_removed <= '0;
        end else begin
            r_done <= 1'b0;

            if (w_cfg_wr) begin
                r_order <= pwdata[0];
            end

            // shadow of the root entry
            if (w_cmd.wr_en && (w_cmd.wr_idx == '0)) begin
                r_root <= signed'(w_cmd.wr_data);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_removed <= '0;
                        r_status  <= ST_OK;
                        unique case (i_req_type)
                            REQ_INSERT: begin
                                if (r_count == CW'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                    r_g     <= r_count[IW-1:0];
                                    r_lvl   <= w_tail_lvl;
                                    r_carry <= i_value;
                                    r_state <= S_UP;
                                end
                            end
                            REQ_EXTRACT: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_removed <= r_root;
                                    r_count   <= r_count - CW'(1);
                                    if (r_count == CW'(1)) begin
                                        r_done <= 1'b1;
                                    end else begin
                                        r_g     <= w_tail[IW-1:0];
                                        r_lvl   <= w_tail_lvl;
                                        r_state <= S_LAST;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_UP: begin
                    if (r_g == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_pend_idx <= w_parent;
                        r_state    <= S_UP_CMP;
                    end
                end
                S_UP_CMP: begin
                    if (w_up_swap) begin
                        r_g     <= r_pend_idx;
                        r_lvl   <= r_lvl - LW'(1);
                        r_state <= S_UP;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_LAST: begin
                    r_state <= S_LAST_WAIT;
                end
                S_LAST_WAIT: begin
                    // last entry goes to the root and sinks from there
                    r_carry <= w_rd;
                    r_best  <= w_rd;
                    r_found <= 1'b0;
                    r_g     <= '0;
                    r_lvl   <= '0;
                    r_j     <= '0;
                    r_pend  <= 1'b0;
                    r_state <= S_DN;
                end
                S_DN: begin
                    if (w_issue) begin
                        r_j        <= r_j + JW'(1);
                        r_pend     <= 1'b1;
                        r_pend_idx <= w_child[IW-1:0];
                    end else begin
                        r_pend <= 1'b0;
                    end

                    if (r_pend && w_dn_better) begin
                        r_best     <= w_rd;
                        r_best_idx <= r_pend_idx;
                        r_found    <= 1'b1;
                    end

                    if (!w_issue && !r_pend) begin
                        if (r_found) begin
                            r_g     <= r_best_idx;
                            r_lvl   <= r_lvl + LW'(1);
                            r_best  <= r_carry;
                            r_found <= 1'b0;
                            r_j     <= '0;
                        end else begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- outputs
    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_entry_count   = r_count;
    assign o_root_valid    = (r_count != '0);
    assign o_root_value    = o_root_valid ? r_root : '0;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_HEAP_ORDER) ? PDATA_W'(r_order) : '0;

endmodule
